@@ hw/rtl/tjm_pkg.sv @@
// Shared types and constants for the touch-to-joypad matrix.
// Holds action codes, button indexes, hit rectangles and packed field widths.
// No dependencies.
`default_nettype none

package tjm_pkg;

    // Event kinds carried in the input tuser field
    typedef enum logic [2:0] {
        ACT_TOUCH_DOWN = 3'd0,
        ACT_TOUCH_UP   = 3'd1,
        ACT_DPAD_FALL  = 3'd2,
        ACT_BTN_FALL   = 3'd3,
        ACT_BTN_RISE   = 3'd4
    } action_t;

    // Button bit positions in the store (1 = released)
    localparam int unsigned BTN_A      = 0;
    localparam int unsigned BTN_B      = 1;
    localparam int unsigned BTN_SELECT = 2;
    localparam int unsigned BTN_START  = 3;
    localparam int unsigned BTN_UP     = 4;
    localparam int unsigned BTN_DOWN   = 5;
    localparam int unsigned BTN_LEFT   = 6;
    localparam int unsigned BTN_RIGHT  = 7;
    localparam int unsigned BTN_HOME   = 8;

    localparam int unsigned NUM_BTN   = 9;
    localparam int unsigned NUM_AREA  = 9;
    localparam int unsigned NUM_LINE  = 4;
    localparam int unsigned X_W       = 10;
    localparam int unsigned Y_W       = 9;

    // Panel pixels per rectangle grid unit
    localparam int unsigned COORD_SCALE = 3;

    // Hit rectangles in test order, grid units; first hit wins
    localparam int unsigned AREA_LEFT [NUM_AREA] =
        '{146, 146, 146, 186, 206, 186, 226, 206, 206};
    localparam int unsigned AREA_TOP  [NUM_AREA] =
        '{ 70,  10, 130,  10,  40, 110, 110, 130,  90};
    localparam int unsigned AREA_W    [NUM_AREA] =
        '{ 10,  10,  10,  20,  20,  20,  20,  20,  20};
    localparam int unsigned AREA_H    [NUM_AREA] =
        '{ 20,  20,  20,  20,  20,  20,  20,  20,  20};
    localparam int unsigned AREA_BTN  [NUM_AREA] =
        '{BTN_HOME, BTN_START, BTN_SELECT, BTN_A, BTN_B,
          BTN_UP, BTN_DOWN, BTN_LEFT, BTN_RIGHT};

    // Hit test result: which button a touch lands on
    typedef struct packed {
        logic                 hit;
        logic [NUM_BTN-1:0]   mask;
    } hit_t;

    // Block state as seen on the result
    typedef struct packed {
        logic                 led;
        logic [NUM_BTN-1:0]   buttons;
        logic [NUM_LINE-1:0]  lines;
    } joy_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/tjm_hit.sv @@
// Rectangle hit test for one touch coordinate pair.
// Compares raw panel coordinates against scaled bounds; uses tjm_pkg.
`default_nettype none

module tjm_hit (
    input  wire logic [tjm_pkg::X_W-1:0] touch_x,
    input  wire logic [tjm_pkg::Y_W-1:0] touch_y,
    output tjm_pkg::hit_t                hit
);

    logic [tjm_pkg::NUM_AREA-1:0] in_area;

    // Test each rectangle; x/3 in [l, l+w) is x in [3l, 3(l+w))
    always_comb
    begin
        for (int i = 0; i < tjm_pkg::NUM_AREA; i++)
        begin
            in_area[i] =
                (touch_x >= tjm_pkg::X_W'(tjm_pkg::COORD_SCALE * tjm_pkg::AREA_LEFT[i])) &&
                (touch_x <  tjm_pkg::X_W'(tjm_pkg::COORD_SCALE *
                                (tjm_pkg::AREA_LEFT[i] + tjm_pkg::AREA_W[i]))) &&
                (touch_y >= tjm_pkg::Y_W'(tjm_pkg::COORD_SCALE * tjm_pkg::AREA_TOP[i])) &&
                (touch_y <  tjm_pkg::Y_W'(tjm_pkg::COORD_SCALE *
                                (tjm_pkg::AREA_TOP[i] + tjm_pkg::AREA_H[i])));
        end
    end

    // Pick the first rectangle hit, walking from the last one back
    always_comb
    begin
        hit.hit  = 1'b0;
        hit.mask = '0;
        for (int i = tjm_pkg::NUM_AREA - 1; i >= 0; i--)
        begin
            if (in_area[i])
            begin
                hit.hit  = 1'b1;
                hit.mask = tjm_pkg::NUM_BTN'(1) << tjm_pkg::AREA_BTN[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tjm_state.sv @@
// Button store, line drive and LED registers with their event update logic.
// Uses tjm_pkg types; driven by the hit test result from tjm_hit.
`default_nettype none

module tjm_state (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire tjm_pkg::action_t  action,
    input  wire logic              overlay_active,
    input  wire tjm_pkg::hit_t     hit,
    output tjm_pkg::joy_state_t    state_next
);

    logic [tjm_pkg::NUM_BTN-1:0]  buttons_reg;
    logic [tjm_pkg::NUM_LINE-1:0] lines_reg;
    logic                         led_reg;

    // Apply one event to the current state
    always_comb
    begin
        state_next.buttons = buttons_reg;
        state_next.lines   = lines_reg;
        state_next.led     = led_reg;
        unique case (action)
            tjm_pkg::ACT_TOUCH_DOWN:
            begin
                state_next.led     = 1'b1;
                if (hit.hit)
                begin
                    state_next.buttons = buttons_reg & ~hit.mask;
                end
            end
            tjm_pkg::ACT_TOUCH_UP:
            begin
                state_next.led     = 1'b0;
                if (hit.hit)
                begin
                    state_next.buttons = buttons_reg | hit.mask;
                end
            end
            tjm_pkg::ACT_DPAD_FALL:
            begin
                if (!overlay_active)
                begin
                    state_next.lines = {buttons_reg[tjm_pkg::BTN_DOWN],
                                        buttons_reg[tjm_pkg::BTN_UP],
                                        buttons_reg[tjm_pkg::BTN_LEFT],
                                        buttons_reg[tjm_pkg::BTN_RIGHT]};
                end
            end
            tjm_pkg::ACT_BTN_FALL:
            begin
                if (!overlay_active)
                begin
                    state_next.lines = {buttons_reg[tjm_pkg::BTN_START],
                                        buttons_reg[tjm_pkg::BTN_SELECT],
                                        buttons_reg[tjm_pkg::BTN_B],
                                        buttons_reg[tjm_pkg::BTN_A]};
                    // Release all four face buttons when all are held
                    if (buttons_reg[tjm_pkg::NUM_LINE-1:0] == '0)
                    begin
                        state_next.buttons[tjm_pkg::NUM_LINE-1:0] = '1;
                    end
                end
            end
            tjm_pkg::ACT_BTN_RISE:
            begin
                if (!overlay_active)
                begin
                    state_next.lines = '1;
                end
            end
            default:
            begin
                state_next.lines = lines_reg;
            end
        endcase
    end

    // Hold state; advance on each event leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buttons_reg <= '1;
            lines_reg   <= '1;
            led_reg     <= 1'b0;
        end
        else if (step)
        begin
            buttons_reg <= state_next.buttons;
            lines_reg   <= state_next.lines;
            led_reg     <= state_next.led;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/touch_to_joypad_matrix.sv @@
// An accepted event passes through the input register, which feeds the result register
// directly; the input register holds while the result register is stalled.
// Throughput: one event per cycle while the output is not stalled.
// Every event gives exactly one result transaction showing the state after it.
// Reset (rst_n low, asynchronous): all buttons released, all lines high, LED off,
// both pipeline registers empty.
// Top level of the touch-to-joypad matrix; instantiates tjm_hit and tjm_state.
`default_nettype none

module touch_to_joypad_matrix (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // touch_x[9:0], touch_y[18:10], overlay_active[19], zero
    input  wire logic [2:0]  s_tuser,   // action[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // joypad_lines[3:0], button_bits[12:4], led_on[13], zero
);

    logic                         in_valid_reg;
    tjm_pkg::action_t             in_action_reg;
    logic [tjm_pkg::X_W-1:0]      in_x_reg;
    logic [tjm_pkg::Y_W-1:0]      in_y_reg;
    logic                         in_overlay_reg;

    logic                         out_valid_reg;
    tjm_pkg::joy_state_t          out_state_reg;

    logic                         advance;
    logic                         step;
    tjm_pkg::hit_t                hit;
    tjm_pkg::joy_state_t          state_next;

    // Move the input register on when the result register frees up
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Capture an input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_action_reg  <= tjm_pkg::action_t'(s_tuser);
            in_x_reg       <= s_tdata[9:0];
            in_y_reg       <= s_tdata[18:10];
            in_overlay_reg <= s_tdata[19];
        end
    end

    tjm_hit u_hit (
        .touch_x (in_x_reg),
        .touch_y (in_y_reg),
        .hit     (hit)
    );

    tjm_state u_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .action         (in_action_reg),
        .overlay_active (in_overlay_reg),
        .hit            (hit),
        .state_next     (state_next)
    );

    // Hold the result until the downstream takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_state_reg <= state_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_state_reg.led, out_state_reg.buttons, out_state_reg.lines};

endmodule

`default_nettype wire

@@ hw/rtl/tjm_checker.sv @@
// Port-level checks for the touch-to-joypad matrix, bound to the top level.
// Sees only the top level's ports; no package dependency.
`default_nettype none

module tjm_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata
);

    // A stalled result stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

    // A stalled result keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result data changed while stalled");

    // An empty output side never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

    // A valid result follows an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
    else $error("no result two cycles after an input transaction");

endmodule

bind touch_to_joypad_matrix tjm_checker u_tjm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ sim/tb_touch_to_joypad_matrix.sv @@
// Self-checking testbench for the touch-to-joypad matrix: drives touch and select events,
// predicts the joypad lines, button store and LED, and compares every result transaction.
// Depends on tjm_pkg and touch_to_joypad_matrix.
`default_nettype none

module tb_touch_to_joypad_matrix;

    import tjm_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_LEN      = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 113;
    localparam int GRID_DIV      = 3;
    localparam int ACT_CODE_MAX  = 7;
    localparam int X_MAX         = 1023;
    localparam int Y_MAX         = 511;

    // Hit areas in test order, grid units
    localparam int HIT_HOME   = 0;
    localparam int HIT_START  = 1;
    localparam int HIT_SELECT = 2;
    localparam int HIT_A      = 3;
    localparam int HIT_B      = 4;
    localparam int HIT_UP     = 5;
    localparam int HIT_DOWN   = 6;
    localparam int HIT_LEFT   = 7;
    localparam int HIT_RIGHT  = 8;
    localparam int HIT_COUNT  = 9;

    localparam int RECT_LEFT [HIT_COUNT] = '{146, 146, 146, 186, 206, 186, 226, 206, 206};
    localparam int RECT_TOP  [HIT_COUNT] = '{ 70,  10, 130,  10,  40, 110, 110, 130,  90};
    localparam int RECT_W    [HIT_COUNT] = '{ 10,  10,  10,  20,  20,  20,  20,  20,  20};
    localparam int RECT_H    [HIT_COUNT] = '{ 20,  20,  20,  20,  20,  20,  20,  20,  20};
    localparam int RECT_BTN  [HIT_COUNT] = '{BTN_HOME, BTN_START, BTN_SELECT, BTN_A, BTN_B,
                                             BTN_UP, BTN_DOWN, BTN_LEFT, BTN_RIGHT};

    typedef struct {
        logic [2:0] act;
        logic [9:0] tx;
        logic [8:0] ty;
        logic       ov;
    } touch_evt_t;

    typedef struct {
        logic [3:0] lines;
        logic [8:0] buttons;
        logic       led;
    } pad_view_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // touch_x[9:0], touch_y[18:10], overlay_active[19], zero
    logic [2:0]  s_tuser = '0;   // action[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // joypad_lines[3:0], button_bits[12:4], led_on[13], zero

    touch_evt_t pending_events[$];
    pad_view_t  expected_pads[$];

    // Predicted block state
    logic [8:0] pad_buttons = '1;
    logic [3:0] pad_lines   = '1;
    logic       pad_led     = 1'b0;

    logic took_evt = 1'b0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   hold_trigger = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   mismatch_count = 0;
    int   cycle_count = 0;

    touch_to_joypad_matrix dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Advance the predicted state by one event
    function automatic void apply_event(input touch_evt_t ev);
        int  gx;
        int  gy;
        logic found;
        gx = int'(ev.tx) / GRID_DIV;
        gy = int'(ev.ty) / GRID_DIV;
        found = 1'b0;
        case (ev.act)
            ACT_TOUCH_DOWN, ACT_TOUCH_UP:
            begin
                pad_led = (ev.act == ACT_TOUCH_DOWN);
                for (int k = 0; k < HIT_COUNT; k++)
                begin
                    if (!found && gx >= RECT_LEFT[k] && gx < RECT_LEFT[k] + RECT_W[k] &&
                        gy >= RECT_TOP[k] && gy < RECT_TOP[k] + RECT_H[k])
                    begin
                        pad_buttons[RECT_BTN[k]] = (ev.act == ACT_TOUCH_UP);
                        found = 1'b1;
                    end
                end
            end
            ACT_DPAD_FALL:
            begin
                if (!ev.ov)
                    pad_lines = {pad_buttons[BTN_DOWN], pad_buttons[BTN_UP],
                                 pad_buttons[BTN_LEFT], pad_buttons[BTN_RIGHT]};
            end
            ACT_BTN_FALL:
            begin
                if (!ev.ov)
                begin
                    pad_lines = {pad_buttons[BTN_START], pad_buttons[BTN_SELECT],
                                 pad_buttons[BTN_B], pad_buttons[BTN_A]};
                    // All four face buttons held: force them released
                    if (pad_buttons[BTN_START:BTN_A] == '0)
                        pad_buttons[BTN_START:BTN_A] = '1;
                end
            end
            ACT_BTN_RISE:
            begin
                if (!ev.ov)
                    pad_lines = '1;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic push_event(input logic [2:0] act, input int x, input int y, input logic ov);
        touch_evt_t ev;
        ev.act = act;
        ev.tx  = 10'(x);
        ev.ty  = 9'(y);
        ev.ov  = ov;
        pending_events.push_back(ev);
    endtask

    // Touch a random point inside one hit area
    task automatic push_on_area(input logic [2:0] act, input int area, input logic ov);
        int gx;
        int gy;
        gx = RECT_LEFT[area] + $urandom_range(RECT_W[area] - 1);
        gy = RECT_TOP[area] + $urandom_range(RECT_H[area] - 1);
        push_event(act, gx * GRID_DIV + $urandom_range(GRID_DIV - 1),
                   gy * GRID_DIV + $urandom_range(GRID_DIV - 1), ov);
    endtask

    task automatic push_noise();
        int r;
        logic [2:0] act;
        r = $urandom_range(99);
        if (r < 30)
            act = ACT_TOUCH_DOWN;
        else if (r < 55)
            act = ACT_TOUCH_UP;
        else if (r < 67)
            act = ACT_DPAD_FALL;
        else if (r < 80)
            act = ACT_BTN_FALL;
        else if (r < 90)
            act = ACT_BTN_RISE;
        else
            act = 3'($urandom_range(ACT_BTN_RISE + 1, ACT_CODE_MAX));
        if ((act == ACT_TOUCH_DOWN || act == ACT_TOUCH_UP) && $urandom_range(99) < 60)
            push_on_area(act, $urandom_range(HIT_COUNT - 1), ($urandom_range(99) < 20));
        else
            push_event(act, $urandom_range(X_MAX), $urandom_range(Y_MAX),
                       ($urandom_range(99) < 20));
    endtask

    // Queue one group of events: mostly well-formed button sequences, some noise
    task automatic add_random_group(output int n);
        int before_cnt;
        int skip;
        int area;
        int r;
        before_cnt = pending_events.size();
        r = $urandom_range(99);
        if (r < 25)
        begin
            // Press the four face buttons, sometimes one short, then read them
            skip = ($urandom_range(99) < 25) ? $urandom_range(HIT_A - HIT_START + 1) : -1;
            for (int k = HIT_START; k <= HIT_B; k++)
            begin
                if (k - HIT_START != skip)
                    push_on_area(ACT_TOUCH_DOWN, k, ($urandom_range(99) < 10));
            end
            push_event(ACT_BTN_FALL, $urandom_range(X_MAX), $urandom_range(Y_MAX),
                       ($urandom_range(99) < 20));
            push_event(ACT_BTN_RISE, $urandom_range(X_MAX), $urandom_range(Y_MAX), 1'b0);
            if ($urandom_range(1))
                push_event(ACT_BTN_FALL, $urandom_range(X_MAX), $urandom_range(Y_MAX), 1'b0);
        end
        else if (r < 50)
        begin
            // Press a d-pad direction and usually release it, around select pulses
            area = $urandom_range(HIT_UP, HIT_RIGHT);
            push_on_area(ACT_TOUCH_DOWN, area, ($urandom_range(99) < 10));
            push_event(ACT_DPAD_FALL, $urandom_range(X_MAX), $urandom_range(Y_MAX),
                       ($urandom_range(99) < 15));
            push_event(ACT_BTN_RISE, $urandom_range(X_MAX), $urandom_range(Y_MAX), 1'b0);
            if ($urandom_range(99) < 70)
                push_on_area(ACT_TOUCH_UP, area, 1'b0);
            push_event(ACT_DPAD_FALL, $urandom_range(X_MAX), $urandom_range(Y_MAX), 1'b0);
        end
        else if (r < 70)
        begin
            // Touch any area, then read a randomly chosen line group
            area = $urandom_range(HIT_COUNT - 1);
            push_on_area($urandom_range(1) ? ACT_TOUCH_DOWN : ACT_TOUCH_UP, area, 1'b0);
            push_event($urandom_range(1) ? ACT_DPAD_FALL : ACT_BTN_FALL,
                       $urandom_range(X_MAX), $urandom_range(Y_MAX), 1'b0);
        end
        else
        begin
            push_noise();
        end
        n = pending_events.size() - before_cnt;
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || s_tvalid || expected_pads.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_directed();
        // Select pulses with every button released
        push_event(ACT_BTN_FALL, 0, 0, 1'b0);
        push_event(ACT_DPAD_FALL, X_MAX, Y_MAX, 1'b0);
        // Press every area at its far corner, home at its near corner
        push_event(ACT_TOUCH_DOWN, RECT_LEFT[HIT_HOME] * GRID_DIV,
                   RECT_TOP[HIT_HOME] * GRID_DIV, 1'b0);
        for (int k = HIT_START; k < HIT_COUNT; k++)
            push_event(ACT_TOUCH_DOWN, (RECT_LEFT[k] + RECT_W[k]) * GRID_DIV - 1,
                       (RECT_TOP[k] + RECT_H[k]) * GRID_DIV - 1, 1'b0);
        // Overlay blocks the d-pad read, then read it for real
        push_event(ACT_DPAD_FALL, 0, 0, 1'b1);
        push_event(ACT_DPAD_FALL, 0, 0, 1'b0);
        // All face buttons held: lines low, store forced to released
        push_event(ACT_BTN_FALL, X_MAX, 0, 1'b0);
        push_event(ACT_BTN_RISE, 0, Y_MAX, 1'b1);
        push_event(ACT_BTN_RISE, 0, 0, 1'b0);
        // Misses: panel edges and just past the home area's right side
        push_event(ACT_TOUCH_UP, X_MAX, Y_MAX, 1'b0);
        push_event(ACT_TOUCH_DOWN, 0, 0, 1'b1);
        push_event(ACT_TOUCH_UP, (RECT_LEFT[HIT_HOME] + RECT_W[HIT_HOME]) * GRID_DIV,
                   RECT_TOP[HIT_HOME] * GRID_DIV, 1'b0);
        // Releases, one under overlay
        push_event(ACT_TOUCH_UP, RECT_LEFT[HIT_HOME] * GRID_DIV + GRID_DIV - 1,
                   RECT_TOP[HIT_HOME] * GRID_DIV, 1'b1);
        push_on_area(ACT_TOUCH_UP, HIT_RIGHT, 1'b0);
        push_event(ACT_DPAD_FALL, 0, 0, 1'b0);
        // Unused action codes
        push_event(3'(ACT_BTN_RISE + 1), X_MAX, Y_MAX, 1'b1);
        push_event(3'(ACT_CODE_MAX), 0, 0, 1'b0);
    endtask

    // Driver: offer queued events, hold each until its transaction completes
    always @(negedge clk)
    begin
        if (took_evt && pending_events.size() != 0)
            void'(pending_events.pop_front());
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !took_evt)
        begin
        end
        else if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= {4'b0, pending_events[0].ov, pending_events[0].ty,
                         pending_events[0].tx};
            s_tuser  <= pending_events[0].act;
        end
        else
            s_tvalid <= 1'b0;
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: predict on each input transaction, check each result transaction
    always @(posedge clk)
    begin
        pad_view_t  want;
        touch_evt_t ev;
        cycle_count <= cycle_count + 1;
        took_evt <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            ev.act = s_tuser;
            ev.tx  = s_tdata[9:0];
            ev.ty  = s_tdata[18:10];
            ev.ov  = s_tdata[19];
            apply_event(ev);
            want.lines   = pad_lines;
            want.buttons = pad_buttons;
            want.led     = pad_led;
            expected_pads.push_back(want);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pads.size() == 0)
            begin
                $display("%0t: result with none expected, got %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_pads.pop_front();
                if (m_tdata[3:0] !== want.lines)
                begin
                    $display("%0t: joypad_lines expected %h got %h",
                             $time, want.lines, m_tdata[3:0]);
                    mismatch_count++;
                end
                if (m_tdata[12:4] !== want.buttons)
                begin
                    $display("%0t: button_bits expected %h got %h",
                             $time, want.buttons, m_tdata[12:4]);
                    mismatch_count++;
                end
                if (m_tdata[13] !== want.led)
                begin
                    $display("%0t: led_on expected %b got %b", $time, want.led, m_tdata[13]);
                    mismatch_count++;
                end
                if (m_tdata[15:14] !== 2'b00)
                begin
                    $display("%0t: padding expected 0 got %b", $time, m_tdata[15:14]);
                    mismatch_count++;
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus: directed events, then four phases of random groups with differing idle and stall rates
    initial
    begin
        int idle_tbl [4];
        int stall_tbl [4];
        int queued;
        int n;
        idle_tbl  = '{0, 67, 0, 16};
        stall_tbl = '{0, 0, 67, 16};
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        push_directed();
        wait_drained();
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_tbl[p];
            stall_pct     = stall_tbl[p];
            // Stall the output for a long stretch while events keep coming
            if (p == 0)
                hold_trigger = hold_trigger + 1;
            queued = 0;
            while (queued < PHASE_ITEMS)
            begin
                add_random_group(n);
                queued += n;
            end
            wait_drained();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_pads.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/tjm_pkg.sv
hw/rtl/tjm_hit.sv
hw/rtl/tjm_state.sv
hw/rtl/touch_to_joypad_matrix.sv
hw/rtl/tjm_checker.sv
sim/tb_touch_to_joypad_matrix.sv
